// ===== src/i2cm_pkg.sv =====
// Shared types and constants for the I2C master byte engine.
// Used by the front end, the sequencer and the top level.
`timescale 1ns / 1ps

package i2cm_pkg;

  typedef enum logic [2:0] {
    KIND_TICK  = 3'd0,
    KIND_START = 3'd1,
    KIND_STOP  = 3'd2,
    KIND_WRITE = 3'd3,
    KIND_READ  = 3'd4
  } kind_t;

  typedef enum logic [2:0] {
    CMD_TICK,
    CMD_START,
    CMD_STOP,
    CMD_WRITE,
    CMD_READ
  } cmd_t;

  typedef enum logic [4:0] {
    PH_IDLE,
    PH_ST1,
    PH_ST2,
    PH_ST3,
    PH_ST4,
    PH_ST5,
    PH_SP1,
    PH_SP2,
    PH_SP3,
    PH_SP4,
    PH_WR_SETUP,
    PH_WR_HIGH,
    PH_WR_LOW,
    PH_AK1,
    PH_AK2,
    PH_AK_POLL,
    PH_RD_HIGH,
    PH_RD_LOW,
    PH_RA_SETUP,
    PH_RA_HIGH
  } phase_t;

  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACK_TIMEOUT = 2'd1;

  localparam logic [15:0] HALF_PERIOD_RST = 16'd5;
  localparam logic [7:0]  ACK_TIMEOUT_RST = 8'd250;
  localparam logic [3:0]  BITS_PER_BYTE   = 4'd8;

  typedef struct packed {
    logic [15:0] half_period;
    logic [7:0]  ack_timeout;
  } cfg_t;

  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] tx_byte;
    logic       nack;
    logic       sda_in;
  } entry_t;

  typedef struct packed {
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_ok;
    logic       timeout;
  } result_t;

endpackage

// ===== src/i2cm_in_if.sv =====
// Command channel: valid/ready handshake plus one command beat.
// Depends on nothing.
`timescale 1ns / 1ps

interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] tx_byte;
  logic       nack;
  logic       sda_in;

  modport source (output valid, output kind, output tx_byte, output nack, output sda_in,
                  input ready);
  modport sink   (input valid, input kind, input tx_byte, input nack, input sda_in,
                  output ready);
endinterface

// ===== src/i2cm_out_if.sv =====
// Result channel: valid/ready handshake plus pin drives and status of one beat.
// Depends on nothing.
`timescale 1ns / 1ps

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_ok;
  logic       timeout;

  modport source (output valid, output scl_out, output sda_out, output busy_res,
                  output done_res, output rx_byte, output ack_ok, output timeout,
                  input ready);
  modport sink   (input valid, input scl_out, input sda_out, input busy_res,
                  input done_res, input rx_byte, input ack_ok, input timeout,
                  output ready);
endinterface

// ===== src/i2cm_cfg_if.sv =====
// Register write channel: valid/ready handshake, register index and write data.
// Depends on nothing.
`timescale 1ns / 1ps

interface i2cm_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/i2cm_front.sv =====
// Front end: accepts command beats, decodes the kind and queues them two deep.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_kind,
  input  logic [7:0]        in_tx_byte,
  input  logic              in_nack,
  input  logic              in_sda_in,
  output logic              q_valid,
  input  logic              q_pop,
  output i2cm_pkg::entry_t  q_entry
);

  i2cm_pkg::entry_t slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  i2cm_pkg::entry_t dec;

  always_comb begin
    dec.tx_byte = in_tx_byte;
    dec.nack    = in_nack;
    dec.sda_in  = in_sda_in;
    unique case (in_kind)
      i2cm_pkg::KIND_START: dec.cmd = i2cm_pkg::CMD_START;
      i2cm_pkg::KIND_STOP:  dec.cmd = i2cm_pkg::CMD_STOP;
      i2cm_pkg::KIND_WRITE: dec.cmd = i2cm_pkg::CMD_WRITE;
      i2cm_pkg::KIND_READ:  dec.cmd = i2cm_pkg::CMD_READ;
      default:              dec.cmd = i2cm_pkg::CMD_TICK;
    endcase
  end

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign q_entry  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    priority case ({push, q_pop})
      2'b10:   count_nxt = count_r + 2'd1;
      2'b01:   count_nxt = count_r - 2'd1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// ===== src/i2cm_back.sv =====
// Back end: bus sequencer that registers the result; one queued beat per cycle while that register is free or drained.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps

module i2cm_back (
  input  logic              clk,
  input  logic              rst_n,
  input  i2cm_pkg::cfg_t    cfg,
  input  logic              q_valid,
  output logic              q_pop,
  input  i2cm_pkg::entry_t  q_entry,
  output logic              out_valid,
  input  logic              out_ready,
  output i2cm_pkg::result_t out_res
);

  i2cm_pkg::phase_t phase_r, phase_nxt;
  logic [3:0]  bit_r, bit_nxt;
  logic [15:0] delay_r, delay_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic [7:0]  poll_r, poll_nxt;
  logic        scl_r, scl_nxt;
  logic        sda_r, sda_nxt;
  logic        ack_r, ack_nxt;
  logic        nack_r, nack_nxt;
  logic [7:0]  rx_r, rx_nxt;
  logic        to_r, to_nxt;
  logic        valid_r, valid_nxt;
  i2cm_pkg::result_t res_r, res_nxt;
  logic        fires;
  logic [15:0] dly_dec;
  logic        done;

  assign q_pop     = q_valid && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_res   = res_r;

  assign fires   = (delay_r <= 16'd1);
  assign dly_dec = fires ? 16'd0 : delay_r - 16'd1;

  always_comb begin
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    delay_nxt = delay_r;
    shift_nxt = shift_r;
    poll_nxt  = poll_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    ack_nxt   = ack_r;
    nack_nxt  = nack_r;
    rx_nxt    = rx_r;
    to_nxt    = to_r;
    done      = 1'b0;
    if (q_pop) begin
      if (phase_r == i2cm_pkg::PH_IDLE) begin
        unique case (q_entry.cmd)
          i2cm_pkg::CMD_START: begin
            delay_nxt = cfg.half_period;
            phase_nxt = i2cm_pkg::PH_ST1;
          end
          i2cm_pkg::CMD_STOP: begin
            sda_nxt   = 1'b0;
            delay_nxt = cfg.half_period;
            phase_nxt = i2cm_pkg::PH_SP1;
          end
          i2cm_pkg::CMD_WRITE: begin
            shift_nxt = q_entry.tx_byte;
            bit_nxt   = 4'd0;
            scl_nxt   = 1'b0;
            sda_nxt   = q_entry.tx_byte[7];
            phase_nxt = i2cm_pkg::PH_WR_SETUP;
          end
          i2cm_pkg::CMD_READ: begin
            shift_nxt = 8'd0;
            bit_nxt   = 4'd0;
            nack_nxt  = q_entry.nack;
            scl_nxt   = 1'b0;
            sda_nxt   = 1'b1;
            delay_nxt = cfg.half_period;
            phase_nxt = i2cm_pkg::PH_RD_LOW;
          end
          default: ;
        endcase
      end else begin
        unique case (phase_r)
          i2cm_pkg::PH_ST1: begin
            delay_nxt = dly_dec;
            if (fires) begin
              sda_nxt   = 1'b1;
              delay_nxt = cfg.half_period;
              phase_nxt = i2cm_pkg::PH_ST2;
            end
          end
          i2cm_pkg::PH_ST2: begin
            delay_nxt = dly_dec;
            if (fires) begin
              scl_nxt   = 1'b1;
              delay_nxt = cfg.half_period;
              phase_nxt = i2cm_pkg::PH_ST3;
            end
          end
          i2cm_pkg::PH_ST3: begin
            delay_nxt = dly_dec;
            if (fires) begin
              sda_nxt   = 1'b0;
              delay_nxt = cfg.half_period;
              phase_nxt = i2cm_pkg::PH_ST4;
            end
          end
          i2cm_pkg::PH_ST4: begin
            delay_nxt = dly_dec;
            if (fires) begin
              scl_nxt   = 1'b0;
              delay_nxt = cfg.half_period;
              phase_nxt = i2cm_pkg::PH_ST5;
            end
          end
          i2cm_pkg::PH_ST5, i2cm_pkg::PH_SP4: begin
            delay_nxt = dly_dec;
            if (fires) begin
              phase_nxt = i2cm_pkg::PH_IDLE;
              done      = 1'b1;
            end
          end
          i2cm_pkg::PH_SP1: begin
            delay_nxt = dly_dec;
            if (fires) begin
              scl_nxt   = 1'b1;
              delay_nxt = cfg.half_period;
              phase_nxt = i2cm_pkg::PH_SP2;
            end
          end
          i2cm_pkg::PH_SP2: begin
            delay_nxt = dly_dec;
            if (fires) begin
              sda_nxt   = 1'b1;
              delay_nxt = cfg.half_period;
              phase_nxt = i2cm_pkg::PH_SP3;
            end
          end
          i2cm_pkg::PH_SP3: begin
            delay_nxt = dly_dec;
            if (fires) begin
              delay_nxt = cfg.half_period;
              phase_nxt = i2cm_pkg::PH_SP4;
            end
          end
          i2cm_pkg::PH_WR_SETUP: begin
            scl_nxt   = 1'b1;
            delay_nxt = cfg.half_period;
            phase_nxt = i2cm_pkg::PH_WR_HIGH;
          end
          i2cm_pkg::PH_WR_HIGH: begin
            delay_nxt = dly_dec;
            if (fires) begin
              scl_nxt   = 1'b0;
              bit_nxt   = bit_r + 4'd1;
              delay_nxt = cfg.half_period;
              phase_nxt = i2cm_pkg::PH_WR_LOW;
            end
          end
          i2cm_pkg::PH_WR_LOW: begin
            delay_nxt = dly_dec;
            if (fires) begin
              if (bit_r < i2cm_pkg::BITS_PER_BYTE) begin
                shift_nxt = {shift_r[6:0], 1'b0};
                sda_nxt   = shift_r[6];
                phase_nxt = i2cm_pkg::PH_WR_SETUP;
              end else begin
                sda_nxt   = 1'b1;
                delay_nxt = cfg.half_period;
                phase_nxt = i2cm_pkg::PH_AK1;
              end
            end
          end
          i2cm_pkg::PH_AK1: begin
            delay_nxt = dly_dec;
            if (fires) begin
              scl_nxt   = 1'b1;
              delay_nxt = cfg.half_period;
              phase_nxt = i2cm_pkg::PH_AK2;
            end
          end
          i2cm_pkg::PH_AK2: begin
            delay_nxt = dly_dec;
            if (fires) begin
              poll_nxt  = 8'd0;
              phase_nxt = i2cm_pkg::PH_AK_POLL;
            end
          end
          i2cm_pkg::PH_AK_POLL: begin
            priority if (!q_entry.sda_in) begin
              ack_nxt   = 1'b1;
              to_nxt    = 1'b0;
              scl_nxt   = 1'b0;
              phase_nxt = i2cm_pkg::PH_IDLE;
              done      = 1'b1;
            end else if (poll_r >= cfg.ack_timeout) begin
              ack_nxt   = 1'b0;
              to_nxt    = 1'b1;
              scl_nxt   = 1'b0;
              phase_nxt = i2cm_pkg::PH_IDLE;
              done      = 1'b1;
            end else begin
              poll_nxt  = poll_r + 8'd1;
            end
          end
          i2cm_pkg::PH_RD_LOW: begin
            delay_nxt = dly_dec;
            if (fires) begin
              if (bit_r < i2cm_pkg::BITS_PER_BYTE) begin
                scl_nxt   = 1'b1;
                delay_nxt = cfg.half_period;
                phase_nxt = i2cm_pkg::PH_RD_HIGH;
              end else begin
                sda_nxt   = nack_r;
                phase_nxt = i2cm_pkg::PH_RA_SETUP;
              end
            end
          end
          i2cm_pkg::PH_RD_HIGH: begin
            delay_nxt = dly_dec;
            if (fires) begin
              shift_nxt = {shift_r[6:0], q_entry.sda_in};
              bit_nxt   = bit_r + 4'd1;
              scl_nxt   = 1'b0;
              delay_nxt = cfg.half_period;
              phase_nxt = i2cm_pkg::PH_RD_LOW;
            end
          end
          i2cm_pkg::PH_RA_SETUP: begin
            scl_nxt   = 1'b1;
            delay_nxt = cfg.half_period;
            phase_nxt = i2cm_pkg::PH_RA_HIGH;
          end
          i2cm_pkg::PH_RA_HIGH: begin
            delay_nxt = dly_dec;
            if (fires) begin
              scl_nxt   = 1'b0;
              rx_nxt    = shift_r;
              phase_nxt = i2cm_pkg::PH_IDLE;
              done      = 1'b1;
            end
          end
          default: phase_nxt = i2cm_pkg::PH_IDLE;
        endcase
      end
    end
  end

  always_comb begin
    res_nxt.scl_out  = scl_nxt;
    res_nxt.sda_out  = sda_nxt;
    res_nxt.busy_res = (phase_nxt != i2cm_pkg::PH_IDLE);
    res_nxt.done_res = done;
    res_nxt.rx_byte  = rx_nxt;
    res_nxt.ack_ok   = ack_nxt;
    res_nxt.timeout  = to_nxt;
    valid_nxt        = q_pop ? 1'b1 : (out_ready ? 1'b0 : valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= i2cm_pkg::PH_IDLE;
      bit_r   <= 4'd0;
      delay_r <= 16'd0;
      shift_r <= 8'd0;
      poll_r  <= 8'd0;
      scl_r   <= 1'b1;
      sda_r   <= 1'b1;
      ack_r   <= 1'b0;
      nack_r  <= 1'b0;
      rx_r    <= 8'd0;
      to_r    <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      bit_r   <= bit_nxt;
      delay_r <= delay_nxt;
      shift_r <= shift_nxt;
      poll_r  <= poll_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      ack_r   <= ack_nxt;
      nack_r  <= nack_nxt;
      rx_r    <= rx_nxt;
      to_r    <= to_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== src/i2c_master_byte_engine.sv =====
// Byte-level I2C master: command front end, two-deep queue, bus sequencer, register file.
// Depends on i2cm_pkg, i2cm_in_if, i2cm_out_if, i2cm_cfg_if, i2cm_front and i2cm_back.
// Each beat on in_ch (a command, or a tick that advances the bus sequence) gives exactly one
// beat on out_ch carrying the SCL/SDA drives and status after it. One beat is taken per clock
// while out_ch keeps taking results; a result passes the two-entry command queue and then the
// result register, is offered on out_ch from there and held until taken, and the sequencer
// runs one queued beat per clock whenever the result register is free or being drained.
// With out_ch stalled, the queue and the result register hold three
// beats before in_ch is stalled. Register writes on cfg_ch are always taken; index 0 sets
// half_period, index 1 sets ack_timeout, other indexes are dropped.
`timescale 1ns / 1ps

module i2c_master_byte_engine (
  input logic              clk,
  input logic              rst_n,
  i2cm_in_if.sink          in_ch,
  i2cm_out_if.source       out_ch,
  i2cm_cfg_if.sink         cfg_ch
);

  i2cm_pkg::cfg_t    cfg_r, cfg_nxt;
  i2cm_pkg::entry_t  q_entry;
  i2cm_pkg::result_t res;
  logic              q_valid;
  logic              q_pop;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      if (cfg_ch.index == i2cm_pkg::REG_HALF_PERIOD) begin
        cfg_nxt.half_period = cfg_ch.data;
      end else if (cfg_ch.index == i2cm_pkg::REG_ACK_TIMEOUT) begin
        cfg_nxt.ack_timeout = cfg_ch.data[7:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period <= i2cm_pkg::HALF_PERIOD_RST;
      cfg_r.ack_timeout <= i2cm_pkg::ACK_TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  i2cm_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_kind    (in_ch.kind),
    .in_tx_byte (in_ch.tx_byte),
    .in_nack    (in_ch.nack),
    .in_sda_in  (in_ch.sda_in),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_entry    (q_entry)
  );

  i2cm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .q_entry   (q_entry),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (res)
  );

  assign out_ch.scl_out  = res.scl_out;
  assign out_ch.sda_out  = res.sda_out;
  assign out_ch.busy_res = res.busy_res;
  assign out_ch.done_res = res.done_res;
  assign out_ch.rx_byte  = res.rx_byte;
  assign out_ch.ack_ok   = res.ack_ok;
  assign out_ch.timeout  = res.timeout;

  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.done_res |-> !out_ch.busy_res)
    else $error("done beat reports busy");

  a_drain_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid && !out_ch.valid |=> out_ch.valid)
    else $error("queued beat not executed while result register free");

  a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("sequencer popped an empty queue");

  a_no_result_from_nothing: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid && !q_valid |=> !out_ch.valid)
    else $error("result beat without a queued command");

endmodule

// ===== verif/i2c_master_byte_engine_tb.sv =====
// Self-checking testbench for the I2C master byte engine: directed and random command beats.
// Predicts every result beat with its own bus sequencer and compares it field by field.
// Depends on i2cm_pkg, the three channel interfaces and i2c_master_byte_engine.
`timescale 1ns / 1ps

module i2c_master_byte_engine_tb;

  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned HOLD_OFF_CYCLES = 80;
  localparam int unsigned RANDOM_ITEMS_PER_PHASE = 30;
  localparam int unsigned BUSY_NOISE_PCT = 5;
  localparam logic [2:0] KIND_RSVD_LO = 3'd5;
  localparam logic [2:0] KIND_RSVD_HI = 3'd7;
  localparam logic [i2cm_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] tx_byte;
    logic       nack;
    logic       sda_in;
  } bus_item_t;

  logic clk = 1'b0;
  logic rst_n;

  i2cm_in_if  in_ch();
  i2cm_out_if out_ch();
  i2cm_cfg_if cfg_ch();

  i2c_master_byte_engine i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Sequencer mirror
  i2cm_pkg::phase_t bus_phase;
  logic [3:0]  bits_done;
  logic [15:0] wait_left;
  logic [7:0]  shreg;
  logic [7:0]  polls;
  logic        scl_drv;
  logic        sda_drv;
  logic        ack_seen;
  logic        nack_pending;
  logic        gave_up;
  logic [7:0]  rx_held;
  logic [15:0] half_period_reg;
  logic [7:0]  ack_timeout_reg;

  i2cm_pkg::result_t pin_states_due[$];
  bus_item_t   cmd_backlog[$];
  bus_item_t   next_beat;
  i2cm_pkg::result_t due_state;

  int unsigned mismatch_count;
  int unsigned results_seen;
  int unsigned stall_count;
  int unsigned send_gap_pct;
  int unsigned stall_pct;
  int unsigned hold_request;
  int unsigned hold_left;
  int unsigned phase_items;
  int          gen_half;
  int          gen_ato;
  logic        in_beat_taken;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic void reset_model();
    half_period_reg = i2cm_pkg::HALF_PERIOD_RST;
    ack_timeout_reg = i2cm_pkg::ACK_TIMEOUT_RST;
    bus_phase = i2cm_pkg::PH_IDLE;
    bits_done = '0;
    wait_left = '0;
    shreg = '0;
    polls = '0;
    scl_drv = 1'b1;
    sda_drv = 1'b1;
    ack_seen = 1'b0;
    nack_pending = 1'b0;
    gave_up = 1'b0;
    rx_held = '0;
  endfunction

  function automatic logic wait_expired();
    if (wait_left <= 16'd1) begin
      wait_left = '0;
      return 1'b1;
    end
    wait_left = wait_left - 16'd1;
    return 1'b0;
  endfunction

  function automatic void arm_wait(i2cm_pkg::phase_t nxt);
    wait_left = half_period_reg;
    bus_phase = nxt;
  endfunction

  function automatic logic step_sequence(logic sda);
    logic fin;
    fin = 1'b0;
    case (bus_phase)
      i2cm_pkg::PH_ST1: if (wait_expired()) begin
        sda_drv = 1'b1;
        arm_wait(i2cm_pkg::PH_ST2);
      end
      i2cm_pkg::PH_ST2: if (wait_expired()) begin
        scl_drv = 1'b1;
        arm_wait(i2cm_pkg::PH_ST3);
      end
      i2cm_pkg::PH_ST3: if (wait_expired()) begin
        sda_drv = 1'b0;
        arm_wait(i2cm_pkg::PH_ST4);
      end
      i2cm_pkg::PH_ST4: if (wait_expired()) begin
        scl_drv = 1'b0;
        arm_wait(i2cm_pkg::PH_ST5);
      end
      i2cm_pkg::PH_ST5: if (wait_expired()) begin
        bus_phase = i2cm_pkg::PH_IDLE;
        fin = 1'b1;
      end
      i2cm_pkg::PH_SP1: if (wait_expired()) begin
        scl_drv = 1'b1;
        arm_wait(i2cm_pkg::PH_SP2);
      end
      i2cm_pkg::PH_SP2: if (wait_expired()) begin
        sda_drv = 1'b1;
        arm_wait(i2cm_pkg::PH_SP3);
      end
      i2cm_pkg::PH_SP3: if (wait_expired()) begin
        arm_wait(i2cm_pkg::PH_SP4);
      end
      i2cm_pkg::PH_SP4: if (wait_expired()) begin
        bus_phase = i2cm_pkg::PH_IDLE;
        fin = 1'b1;
      end
      i2cm_pkg::PH_WR_SETUP: begin
        scl_drv = 1'b1;
        arm_wait(i2cm_pkg::PH_WR_HIGH);
      end
      i2cm_pkg::PH_WR_HIGH: if (wait_expired()) begin
        scl_drv = 1'b0;
        bits_done = bits_done + 4'd1;
        arm_wait(i2cm_pkg::PH_WR_LOW);
      end
      i2cm_pkg::PH_WR_LOW: if (wait_expired()) begin
        if (bits_done < i2cm_pkg::BITS_PER_BYTE) begin
          shreg = shreg << 1;
          sda_drv = shreg[7];
          bus_phase = i2cm_pkg::PH_WR_SETUP;
        end else begin
          sda_drv = 1'b1;
          arm_wait(i2cm_pkg::PH_AK1);
        end
      end
      i2cm_pkg::PH_AK1: if (wait_expired()) begin
        scl_drv = 1'b1;
        arm_wait(i2cm_pkg::PH_AK2);
      end
      i2cm_pkg::PH_AK2: if (wait_expired()) begin
        polls = '0;
        bus_phase = i2cm_pkg::PH_AK_POLL;
      end
      i2cm_pkg::PH_AK_POLL: begin
        if (!sda) begin
          ack_seen = 1'b1;
          gave_up = 1'b0;
          scl_drv = 1'b0;
          bus_phase = i2cm_pkg::PH_IDLE;
          fin = 1'b1;
        end else if (polls >= ack_timeout_reg) begin
          ack_seen = 1'b0;
          gave_up = 1'b1;
          scl_drv = 1'b0;
          bus_phase = i2cm_pkg::PH_IDLE;
          fin = 1'b1;
        end else begin
          polls = polls + 8'd1;
        end
      end
      i2cm_pkg::PH_RD_LOW: if (wait_expired()) begin
        if (bits_done < i2cm_pkg::BITS_PER_BYTE) begin
          scl_drv = 1'b1;
          arm_wait(i2cm_pkg::PH_RD_HIGH);
        end else begin
          sda_drv = nack_pending;
          bus_phase = i2cm_pkg::PH_RA_SETUP;
        end
      end
      i2cm_pkg::PH_RD_HIGH: if (wait_expired()) begin
        shreg = {shreg[6:0], sda};
        bits_done = bits_done + 4'd1;
        scl_drv = 1'b0;
        arm_wait(i2cm_pkg::PH_RD_LOW);
      end
      i2cm_pkg::PH_RA_SETUP: begin
        scl_drv = 1'b1;
        arm_wait(i2cm_pkg::PH_RA_HIGH);
      end
      i2cm_pkg::PH_RA_HIGH: if (wait_expired()) begin
        scl_drv = 1'b0;
        rx_held = shreg;
        bus_phase = i2cm_pkg::PH_IDLE;
        fin = 1'b1;
      end
      default: bus_phase = i2cm_pkg::PH_IDLE;
    endcase
    return fin;
  endfunction

  function automatic i2cm_pkg::result_t predict_pin_state(bus_item_t it);
    i2cm_pkg::result_t r;
    logic    fin;
    fin = 1'b0;
    if (bus_phase == i2cm_pkg::PH_IDLE) begin
      case (it.kind)
        i2cm_pkg::KIND_START: arm_wait(i2cm_pkg::PH_ST1);
        i2cm_pkg::KIND_STOP: begin
          sda_drv = 1'b0;
          arm_wait(i2cm_pkg::PH_SP1);
        end
        i2cm_pkg::KIND_WRITE: begin
          shreg = it.tx_byte;
          bits_done = '0;
          scl_drv = 1'b0;
          sda_drv = it.tx_byte[7];
          bus_phase = i2cm_pkg::PH_WR_SETUP;
        end
        i2cm_pkg::KIND_READ: begin
          shreg = '0;
          bits_done = '0;
          nack_pending = it.nack;
          scl_drv = 1'b0;
          sda_drv = 1'b1;
          arm_wait(i2cm_pkg::PH_RD_LOW);
        end
        default: ;
      endcase
    end else begin
      fin = step_sequence(it.sda_in);
    end
    r.scl_out = scl_drv;
    r.sda_out = sda_drv;
    r.busy_res = (bus_phase != i2cm_pkg::PH_IDLE);
    r.done_res = fin;
    r.rx_byte = rx_held;
    r.ack_ok = ack_seen;
    r.timeout = gave_up;
    return r;
  endfunction

  task automatic report_failure(string msg);
    $display("%s", msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      report_failure($sformatf("result %0d %s: got %0h, expected %0h",
                               results_seen, name, got, want));
  endtask

  // Sample handshakes and update the mirror
  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
      pin_states_due.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          i2cm_pkg::REG_HALF_PERIOD: half_period_reg = cfg_ch.data;
          i2cm_pkg::REG_ACK_TIMEOUT: ack_timeout_reg = cfg_ch.data[7:0];
          default: ;
        endcase
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (pin_states_due.size() == 0) begin
          report_failure($sformatf("result %0d arrived with nothing outstanding", results_seen));
        end else begin
          due_state = pin_states_due.pop_front();
          check_field("scl_out", 8'(out_ch.scl_out), 8'(due_state.scl_out));
          check_field("sda_out", 8'(out_ch.sda_out), 8'(due_state.sda_out));
          check_field("busy_res", 8'(out_ch.busy_res), 8'(due_state.busy_res));
          check_field("done_res", 8'(out_ch.done_res), 8'(due_state.done_res));
          check_field("rx_byte", out_ch.rx_byte, due_state.rx_byte);
          check_field("ack_ok", 8'(out_ch.ack_ok), 8'(due_state.ack_ok));
          check_field("timeout", 8'(out_ch.timeout), 8'(due_state.timeout));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        pin_states_due.push_back(predict_pin_state(
          bus_item_t'{in_ch.kind, in_ch.tx_byte, in_ch.nack, in_ch.sda_in}));
        in_beat_taken = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        stall_count = 0;
      end else begin
        stall_count++;
      end
      if (stall_count >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Command driver
  always @(negedge clk) begin
    if (rst_n && (!in_ch.valid || in_beat_taken)) begin
      in_beat_taken = 1'b0;
      if (cmd_backlog.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
        next_beat = cmd_backlog.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.kind    <= next_beat.kind;
        in_ch.tx_byte <= next_beat.tx_byte;
        in_ch.nack    <= next_beat.nack;
        in_ch.sda_in  <= next_beat.sda_in;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver
  always @(negedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic push_beat(logic [2:0] kind, logic [7:0] tx, logic nk, logic sda);
    cmd_backlog.push_back(bus_item_t'{kind, tx, nk, sda});
    phase_items++;
  endtask

  task automatic push_ticks(int n, int noise_pct);
    logic [2:0] k;
    repeat (n) begin
      k = i2cm_pkg::KIND_TICK;
      if ($urandom_range(0, 99) < noise_pct)
        k = 3'($urandom_range(i2cm_pkg::KIND_START, KIND_RSVD_HI));
      push_beat(k, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    end
  endtask

  // Command beat plus enough ticks to finish it; ack_highs is the high count in the ACK slot
  task automatic run_command(logic [2:0] kind, logic [7:0] tx, logic nk, int ack_highs,
                             int noise_pct);
    int w;
    int i;
    w = (gen_half == 0) ? 1 : gen_half;
    push_beat(kind, tx, nk, 1'($urandom_range(0, 1)));
    case (kind)
      i2cm_pkg::KIND_START: push_ticks(5 * w, noise_pct);
      i2cm_pkg::KIND_STOP: push_ticks(4 * w, noise_pct);
      i2cm_pkg::KIND_READ: push_ticks(18 * w + 1, noise_pct);
      i2cm_pkg::KIND_WRITE: begin
        push_ticks(8 * (2 * w + 1) + 2 * w, noise_pct);
        for (i = 0; i < ack_highs && i <= gen_ato; i++)
          push_beat(i2cm_pkg::KIND_TICK, 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 1'b1);
        if (ack_highs <= gen_ato)
          push_beat(i2cm_pkg::KIND_TICK, 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 1'b0);
      end
      default: ;
    endcase
  endtask

  task automatic write_reg(logic [i2cm_pkg::CFG_IDX_W-1:0] idx,
                           logic [i2cm_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == i2cm_pkg::REG_HALF_PERIOD) gen_half = int'(val);
    else if (idx == i2cm_pkg::REG_ACK_TIMEOUT) gen_ato = int'(val[7:0]);
  endtask

  task automatic wait_for_drain();
    do @(posedge clk);
    while (cmd_backlog.size() != 0 || in_ch.valid || pin_states_due.size() != 0);
  endtask

  task automatic random_phase(int gap_pct, int stall, bit pressure);
    int pick;
    write_reg(i2cm_pkg::REG_HALF_PERIOD, 16'($urandom_range(0, 3)));
    write_reg(i2cm_pkg::REG_ACK_TIMEOUT,
              {8'($urandom_range(0, 255)), 8'($urandom_range(0, 12))});
    send_gap_pct = gap_pct;
    stall_pct = stall;
    phase_items = 0;
    while (phase_items < RANDOM_ITEMS_PER_PHASE) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        run_command(i2cm_pkg::KIND_START, 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 0, BUSY_NOISE_PCT);
      end else if (pick < 24) begin
        run_command(i2cm_pkg::KIND_STOP, 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 0, BUSY_NOISE_PCT);
      end else if (pick < 55) begin
        run_command(i2cm_pkg::KIND_WRITE, 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), int'($urandom_range(0, gen_ato + 1)),
                    BUSY_NOISE_PCT);
      end else if (pick < 85) begin
        run_command(i2cm_pkg::KIND_READ, 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), 0, BUSY_NOISE_PCT);
      end else if (pick < 93) begin
        push_beat(3'($urandom_range(0, 1) ? i2cm_pkg::KIND_TICK :
                     $urandom_range(KIND_RSVD_LO, KIND_RSVD_HI)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
      end else begin
        // cut a command short and crowd it with others
        push_beat(3'($urandom_range(i2cm_pkg::KIND_START, i2cm_pkg::KIND_READ)),
                  8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
        push_ticks(int'($urandom_range(1, 6)), 30);
      end
    end
    if (pressure) hold_request = HOLD_OFF_CYCLES;
    wait_for_drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind = i2cm_pkg::KIND_TICK;
    in_ch.tx_byte = '0;
    in_ch.nack = 1'b0;
    in_ch.sda_in = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    send_gap_pct = 0;
    stall_pct = 0;
    hold_request = 0;
    hold_left = 0;
    mismatch_count = 0;
    results_seen = 0;
    stall_count = 0;
    phase_items = 0;
    in_beat_taken = 1'b0;
    gen_half = int'(i2cm_pkg::HALF_PERIOD_RST);
    gen_ato = int'(i2cm_pkg::ACK_TIMEOUT_RST);
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset state, reserved kinds while idle, start at reset timing
    push_beat(i2cm_pkg::KIND_TICK, 8'h00, 1'b0, 1'b0);
    push_beat(KIND_RSVD_HI, 8'hFF, 1'b1, 1'b1);
    push_beat(KIND_RSVD_LO, 8'h00, 1'b0, 1'b1);
    run_command(i2cm_pkg::KIND_START, 8'h00, 1'b0, 0, 0);
    wait_for_drain();

    // zero delay, zero ACK timeout, dropped register index
    write_reg(i2cm_pkg::REG_HALF_PERIOD, 16'd0);
    write_reg(i2cm_pkg::REG_ACK_TIMEOUT, 16'd0);
    write_reg(REG_UNUSED, 16'hFFFF);
    run_command(i2cm_pkg::KIND_WRITE, 8'hFF, 1'b1, 0, 0);
    run_command(i2cm_pkg::KIND_WRITE, 8'h00, 1'b0, 1, 0);
    run_command(i2cm_pkg::KIND_READ, 8'hFF, 1'b1, 0, 0);
    run_command(i2cm_pkg::KIND_READ, 8'h00, 1'b0, 0, 0);
    // commands arriving while busy are dropped
    push_beat(i2cm_pkg::KIND_START, 8'h00, 1'b0, 1'b0);
    push_beat(i2cm_pkg::KIND_WRITE, 8'hA5, 1'b1, 1'b0);
    push_beat(i2cm_pkg::KIND_READ, 8'h5A, 1'b1, 1'b1);
    push_beat(i2cm_pkg::KIND_STOP, 8'hFF, 1'b0, 1'b0);
    push_ticks(2, 0);
    run_command(i2cm_pkg::KIND_STOP, 8'h00, 1'b0, 0, 0);
    wait_for_drain();

    // longest ACK wait gives up
    write_reg(i2cm_pkg::REG_HALF_PERIOD, 16'd1);
    write_reg(i2cm_pkg::REG_ACK_TIMEOUT, 16'h00FF);
    run_command(i2cm_pkg::KIND_WRITE, 8'h5A, 1'b0, 256, 0);
    wait_for_drain();

    // wider delay phase, upper bits of the timeout write dropped
    write_reg(i2cm_pkg::REG_HALF_PERIOD, 16'd12);
    write_reg(i2cm_pkg::REG_ACK_TIMEOUT, 16'hAB07);
    run_command(i2cm_pkg::KIND_STOP, 8'h00, 1'b0, 0, 0);
    push_beat(i2cm_pkg::KIND_TICK, 8'h00, 1'b0, 1'b1);
    wait_for_drain();

    random_phase(0, 0, 1'b1);
    random_phase(57, 0, 1'b0);
    random_phase(0, 57, 1'b0);
    random_phase(22, 22, 1'b0);

    repeat (10) @(posedge clk);
    if (pin_states_due.size() != 0)
      report_failure($sformatf("%0d results never arrived", pin_states_due.size()));
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/i2cm_pkg.sv
src/i2cm_in_if.sv
src/i2cm_out_if.sv
src/i2cm_cfg_if.sv
src/i2cm_front.sv
src/i2cm_back.sv
src/i2c_master_byte_engine.sv
verif/i2c_master_byte_engine_tb.sv
